@@ src/variable_partition_allocator_top_assert.svh @@
// Assertion macros for the partition allocator checker.
// No dependencies; expects i_clk and i_rst_n in the scope of use.
`ifndef VARIABLE_PARTITION_ALLOCATOR_TOP_ASSERT_SVH
`define VARIABLE_PARTITION_ALLOCATOR_TOP_ASSERT_SVH

// same-cycle implication
`define VPA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define VPA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/vpa_pkg.sv @@
// Shared types and constants of the variable partition allocator.
// No dependencies.
package vpa_pkg;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int ADDR_BITS_DEF   = 16;
    localparam int OWNER_BITS_DEF  = 8;
    localparam int PADDR_BITS      = 3;
    localparam int MSIZE_RESET     = 512;

    localparam logic [PADDR_BITS-1:0] REG_STRATEGY = 3'd0;
    localparam logic [PADDR_BITS-1:0] REG_MEM_SIZE = 3'd4;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_NEXT  = 2'd2;
    localparam logic [1:0] FIT_NONE  = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_FIT   = 2'd1;
    localparam logic [1:0] ST_BAD_FREE = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_PICK,
        S_SH_RD,
        S_SH_WR,
        S_WR_REM,
        S_WR_OWN,
        S_F_IDX,
        S_F_PREV,
        S_F_NEXT,
        S_F_WR,
        S_MV_RD,
        S_MV_WR,
        S_DONE
    } t_state;

endpackage

@@ src/variable_partition_allocator_top.sv @@
// Variable partition allocator, top level.
// Depends on vpa_pkg; the partition table is a local synchronous memory.
//
// One item at a time. An allocate reads the table one entry per cycle, then a split moves
// every entry behind the chosen one up by one and writes the remainder and the owned entry.
// A free reads the entry and its neighbors and writes the merged one, then moves the entries
// behind the merged span down to close the gap. The table has a single read port and a
// single write port. After reset and after each write of memory_size the block stalls while
// it writes the single free partition. A result waits in an output register, so a new item
// may be taken while the previous result is still stalled.
module variable_partition_allocator_top #(
    parameter int MAX_ENTRIES = vpa_pkg::MAX_ENTRIES_DEF,
    parameter int ADDR_BITS   = vpa_pkg::ADDR_BITS_DEF,
    parameter int OWNER_BITS  = vpa_pkg::OWNER_BITS_DEF,
    localparam int IW = $clog2(MAX_ENTRIES),
    localparam int CW = $clog2(MAX_ENTRIES + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [vpa_pkg::PADDR_BITS-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_opcode,
    input  logic [ADDR_BITS-1:0]          i_request_size,
    input  logic [OWNER_BITS-1:0]         i_owner_id,
    input  logic [IW-1:0]                 i_entry_index,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [1:0]                    o_status,
    output logic [IW-1:0]                 o_granted_index,
    output logic [ADDR_BITS-1:0]          o_start_address,
    output logic [CW-1:0]                 o_entry_count
);

    localparam int EW = 2 * ADDR_BITS + OWNER_BITS;

    logic [EW-1:0] mem [MAX_ENTRIES];

    vpa_pkg::t_state r_state, n_state;
    logic                  r_init, n_init;
    logic [1:0]            r_strategy;
    logic [ADDR_BITS-1:0]  r_msize;
    logic [CW-1:0]         r_used, n_used;
    logic [IW-1:0]         r_cursor, n_cursor;
    logic [ADDR_BITS-1:0]  r_want, n_want;
    logic [OWNER_BITS-1:0] r_owner, n_owner;
    logic [IW-1:0]         r_idx, n_idx;
    logic [IW-1:0]         r_pos, n_pos;
    logic [CW-1:0]         r_n, n_n;
    logic                  r_chk, n_chk;
    logic [IW-1:0]         r_chk_pos, n_chk_pos;
    logic                  r_found, n_found;
    logic [IW-1:0]         r_sel_pos, n_sel_pos;
    logic [ADDR_BITS-1:0]  r_sel_start, n_sel_start;
    logic [ADDR_BITS-1:0]  r_sel_size, n_sel_size;
    logic [CW-1:0]         r_k, n_k;
    logic [IW-1:0]         r_lo, n_lo;
    logic [IW-1:0]         r_hi, n_hi;
    logic [ADDR_BITS-1:0]  r_lo_start, n_lo_start;
    logic [ADDR_BITS-1:0]  r_sum, n_sum;
    logic [1:0]            r_res_status, n_res_status;
    logic [IW-1:0]         r_res_gidx, n_res_gidx;
    logic [ADDR_BITS-1:0]  r_res_addr, n_res_addr;
    logic                  r_out_valid, n_out_valid;
    logic [1:0]            r_out_status, n_out_status;
    logic [IW-1:0]         r_out_gidx, n_out_gidx;
    logic [ADDR_BITS-1:0]  r_out_addr, n_out_addr;
    logic [CW-1:0]         r_out_count, n_out_count;
    logic [EW-1:0]         r_rd_data;

    logic                  w_we;
    logic [IW-1:0]         w_waddr;
    logic [EW-1:0]         w_wdata;
    logic                  w_re;
    logic [IW-1:0]         w_raddr;
    logic                  w_cfg_wr;

    logic [ADDR_BITS-1:0]  rd_start;
    logic [ADDR_BITS-1:0]  rd_size;
    logic [OWNER_BITS-1:0] rd_owner;

    assign rd_start = r_rd_data[EW-1 -: ADDR_BITS];
    assign rd_size  = r_rd_data[OWNER_BITS +: ADDR_BITS];
    assign rd_owner = r_rd_data[OWNER_BITS-1:0];

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_comb begin
        prdata = '0;
        unique case (paddr)
            vpa_pkg::REG_STRATEGY: prdata = 32'(r_strategy);
            vpa_pkg::REG_MEM_SIZE: prdata = 32'(r_msize);
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strategy <= vpa_pkg::FIT_FIRST;
            r_msize    <= ADDR_BITS'(vpa_pkg::MSIZE_RESET);
        end else if (w_cfg_wr) begin
            unique case (paddr)
                vpa_pkg::REG_STRATEGY: r_strategy <= pwdata[1:0];
                vpa_pkg::REG_MEM_SIZE: r_msize    <= ADDR_BITS'(pwdata[15:0]);
                default: ;
            endcase
        end
    end

    assign o_in_stall      = (r_state != vpa_pkg::S_IDLE) || r_init;
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_granted_index = r_out_gidx;
    assign o_start_address = r_out_addr;
    assign o_entry_count   = r_out_count;

    // table memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd_data <= mem[w_raddr];
        end
    end

    always_comb begin
        logic          hit;
        logic          issue;
        logic [CW-1:0] nxt;
        logic [IW-1:0] d;

        n_state      = r_state;
        n_init       = r_init;
        n_used       = r_used;
        n_cursor     = r_cursor;
        n_want       = r_want;
        n_owner      = r_owner;
        n_idx        = r_idx;
        n_pos        = r_pos;
        n_n          = r_n;
        n_chk        = 1'b0;
        n_chk_pos    = r_pos;
        n_found      = r_found;
        n_sel_pos    = r_sel_pos;
        n_sel_start  = r_sel_start;
        n_sel_size   = r_sel_size;
        n_k          = r_k;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_lo_start   = r_lo_start;
        n_sum        = r_sum;
        n_res_status = r_res_status;
        n_res_gidx   = r_res_gidx;
        n_res_addr   = r_res_addr;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_status = r_out_status;
        n_out_gidx   = r_out_gidx;
        n_out_addr   = r_out_addr;
        n_out_count  = r_out_count;
        w_we         = 1'b0;
        w_waddr      = '0;
        w_wdata      = '0;
        w_re         = 1'b0;
        w_raddr      = '0;
        hit          = r_chk && (rd_owner == '0) && (rd_size >= r_want);
        issue        = 1'b0;
        nxt          = CW'(r_pos) + CW'(1);
        d            = r_hi - r_lo;

        unique case (r_state)
            vpa_pkg::S_IDLE: begin
                if (r_init) begin
                    w_we     = 1'b1;
                    w_waddr  = '0;
                    w_wdata  = {ADDR_BITS'(0), r_msize, OWNER_BITS'(0)};
                    n_used   = CW'(1);
                    n_cursor = '0;
                    n_init   = 1'b0;
                end else if (i_in_valid) begin
                    n_want       = i_request_size;
                    n_owner      = i_owner_id;
                    n_idx        = i_entry_index;
                    n_res_status = vpa_pkg::ST_OK;
                    n_res_gidx   = '0;
                    n_res_addr   = '0;
                    if (i_opcode == vpa_pkg::OP_FREE) begin
                        if (CW'(i_entry_index) >= r_used) begin
                            n_res_status = vpa_pkg::ST_BAD_FREE;
                            n_state      = vpa_pkg::S_DONE;
                        end else begin
                            w_re    = 1'b1;
                            w_raddr = i_entry_index;
                            n_state = vpa_pkg::S_F_IDX;
                        end
                    end else if (i_request_size == '0 || i_owner_id == '0 ||
                                 r_strategy == vpa_pkg::FIT_NONE) begin
                        n_res_status = vpa_pkg::ST_NO_FIT;
                        n_state      = vpa_pkg::S_DONE;
                    end else begin
                        n_pos   = (r_strategy == vpa_pkg::FIT_NEXT &&
                                   CW'(r_cursor) < r_used) ? r_cursor : '0;
                        n_n     = '0;
                        n_found = 1'b0;
                        n_state = vpa_pkg::S_SCAN;
                    end
                end
            end

            // one read issued per cycle, the previous one checked
            vpa_pkg::S_SCAN: begin
                if (hit && r_strategy != vpa_pkg::FIT_BEST) begin
                    n_found     = 1'b1;
                    n_sel_pos   = r_chk_pos;
                    n_sel_start = rd_start;
                    n_sel_size  = rd_size;
                    n_state     = vpa_pkg::S_PICK;
                end else begin
                    if (hit && (!r_found || rd_size < r_sel_size)) begin
                        n_found     = 1'b1;
                        n_sel_pos   = r_chk_pos;
                        n_sel_start = rd_start;
                        n_sel_size  = rd_size;
                    end
                    issue = (r_n < r_used);
                    if (issue) begin
                        w_re      = 1'b1;
                        w_raddr   = r_pos;
                        n_chk     = 1'b1;
                        n_chk_pos = r_pos;
                        n_n       = r_n + CW'(1);
                        n_pos     = (nxt < r_used) ? nxt[IW-1:0] : '0;
                    end else if (!r_chk) begin
                        n_state = vpa_pkg::S_PICK;
                    end
                end
            end

            vpa_pkg::S_PICK: begin
                if (!r_found) begin
                    n_res_status = vpa_pkg::ST_NO_FIT;
                    n_state      = vpa_pkg::S_DONE;
                end else if (r_sel_size > r_want) begin
                    if (r_used == CW'(MAX_ENTRIES)) begin
                        n_res_status = vpa_pkg::ST_FULL;
                        n_state      = vpa_pkg::S_DONE;
                    end else begin
                        n_k = r_used - CW'(1);
                        if (r_used - CW'(1) > CW'(r_sel_pos)) begin
                            n_state = vpa_pkg::S_SH_RD;
                        end else begin
                            n_state = vpa_pkg::S_WR_REM;
                        end
                    end
                end else begin
                    n_state = vpa_pkg::S_WR_OWN;
                end
            end

            // move entries behind the split up by one, last first
            vpa_pkg::S_SH_RD: begin
                w_re    = 1'b1;
                w_raddr = r_k[IW-1:0];
                n_state = vpa_pkg::S_SH_WR;
            end

            vpa_pkg::S_SH_WR: begin
                w_we    = 1'b1;
                w_waddr = r_k[IW-1:0] + IW'(1);
                w_wdata = r_rd_data;
                if (r_k[IW-1:0] == r_sel_pos + IW'(1)) begin
                    n_state = vpa_pkg::S_WR_REM;
                end else begin
                    n_k     = r_k - CW'(1);
                    n_state = vpa_pkg::S_SH_RD;
                end
            end

            vpa_pkg::S_WR_REM: begin
                w_we    = 1'b1;
                w_waddr = r_sel_pos + IW'(1);
                w_wdata = {r_sel_start + r_want, r_sel_size - r_want, OWNER_BITS'(0)};
                n_used  = r_used + CW'(1);
                n_state = vpa_pkg::S_WR_OWN;
            end

            vpa_pkg::S_WR_OWN: begin
                w_we    = 1'b1;
                w_waddr = r_sel_pos;
                w_wdata = {r_sel_start, r_want, r_owner};
                if (r_strategy == vpa_pkg::FIT_NEXT) begin
                    n_cursor = r_sel_pos;
                end
                n_res_gidx = r_sel_pos;
                n_res_addr = r_sel_start;
                n_state    = vpa_pkg::S_DONE;
            end

            vpa_pkg::S_F_IDX: begin
                if (rd_owner == '0) begin
                    n_res_status = vpa_pkg::ST_BAD_FREE;
                    n_state      = vpa_pkg::S_DONE;
                end else begin
                    n_lo       = r_idx;
                    n_hi       = r_idx;
                    n_lo_start = rd_start;
                    n_sum      = rd_size;
                    if (r_idx != '0) begin
                        w_re    = 1'b1;
                        w_raddr = r_idx - IW'(1);
                        n_state = vpa_pkg::S_F_PREV;
                    end else if (CW'(r_idx) + CW'(1) < r_used) begin
                        w_re    = 1'b1;
                        w_raddr = r_idx + IW'(1);
                        n_state = vpa_pkg::S_F_NEXT;
                    end else begin
                        n_state = vpa_pkg::S_F_WR;
                    end
                end
            end

            vpa_pkg::S_F_PREV: begin
                if (rd_owner == '0) begin
                    n_lo       = r_idx - IW'(1);
                    n_lo_start = rd_start;
                    n_sum      = r_sum + rd_size;
                end
                if (CW'(r_idx) + CW'(1) < r_used) begin
                    w_re    = 1'b1;
                    w_raddr = r_idx + IW'(1);
                    n_state = vpa_pkg::S_F_NEXT;
                end else begin
                    n_state = vpa_pkg::S_F_WR;
                end
            end

            vpa_pkg::S_F_NEXT: begin
                if (rd_owner == '0) begin
                    n_hi  = r_idx + IW'(1);
                    n_sum = r_sum + rd_size;
                end
                n_state = vpa_pkg::S_F_WR;
            end

            // merged free entry at lo; entries past hi close the gap of d slots
            vpa_pkg::S_F_WR: begin
                w_we    = 1'b1;
                w_waddr = r_lo;
                w_wdata = {r_lo_start, r_sum, OWNER_BITS'(0)};
                n_k     = CW'(r_hi) + CW'(1);
                if (d == '0) begin
                    n_state = vpa_pkg::S_DONE;
                end else if (CW'(r_hi) + CW'(1) < r_used) begin
                    n_state = vpa_pkg::S_MV_RD;
                end else begin
                    n_used  = r_used - CW'(d);
                    n_state = vpa_pkg::S_DONE;
                end
            end

            vpa_pkg::S_MV_RD: begin
                w_re    = 1'b1;
                w_raddr = r_k[IW-1:0];
                n_state = vpa_pkg::S_MV_WR;
            end

            vpa_pkg::S_MV_WR: begin
                w_we    = 1'b1;
                w_waddr = r_k[IW-1:0] - d;
                w_wdata = r_rd_data;
                n_k     = r_k + CW'(1);
                if (r_k + CW'(1) < r_used) begin
                    n_state = vpa_pkg::S_MV_RD;
                end else begin
                    n_used  = r_used - CW'(d);
                    n_state = vpa_pkg::S_DONE;
                end
            end

            vpa_pkg::S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_gidx   = r_res_gidx;
                    n_out_addr   = r_res_addr;
                    n_out_count  = r_used;
                    n_state      = vpa_pkg::S_IDLE;
                end
            end

            default: n_state = vpa_pkg::S_IDLE;
        endcase

        if (w_cfg_wr && paddr == vpa_pkg::REG_MEM_SIZE) begin
            n_init = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= vpa_pkg::S_IDLE;
            r_init      <= 1'b1;
            r_used      <= CW'(1);
            r_cursor    <= '0;
            r_chk       <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_init      <= n_init;
            r_used      <= n_used;
            r_cursor    <= n_cursor;
            r_chk       <= n_chk;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_want       <= n_want;
        r_owner      <= n_owner;
        r_idx        <= n_idx;
        r_pos        <= n_pos;
        r_n          <= n_n;
        r_chk_pos    <= n_chk_pos;
        r_sel_pos    <= n_sel_pos;
        r_sel_start  <= n_sel_start;
        r_sel_size   <= n_sel_size;
        r_k          <= n_k;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_lo_start   <= n_lo_start;
        r_sum        <= n_sum;
        r_res_status <= n_res_status;
        r_res_gidx   <= n_res_gidx;
        r_res_addr   <= n_res_addr;
        r_out_status <= n_out_status;
        r_out_gidx   <= n_out_gidx;
        r_out_addr   <= n_out_addr;
        r_out_count  <= n_out_count;
    end

endmodule

@@ src/vpa_checker.sv @@
// Port-level checks of the partition allocator, bound to the top level.
// Depends on vpa_pkg and variable_partition_allocator_top_assert.svh.
`include "variable_partition_allocator_top_assert.svh"

module vpa_checker #(
    parameter int MAX_ENTRIES = vpa_pkg::MAX_ENTRIES_DEF,
    parameter int ADDR_BITS   = vpa_pkg::ADDR_BITS_DEF,
    localparam int IW = $clog2(MAX_ENTRIES),
    localparam int CW = $clog2(MAX_ENTRIES + 1)
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           psel,
    input logic                           penable,
    input logic                           pwrite,
    input logic [vpa_pkg::PADDR_BITS-1:0] paddr,
    input logic                           o_in_stall,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input logic [1:0]                     o_status,
    input logic [IW-1:0]                  o_granted_index,
    input logic [ADDR_BITS-1:0]           o_start_address,
    input logic [CW-1:0]                  o_entry_count
);

    `VPA_ASSERT_NXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_status) && $stable(o_start_address) && $stable(o_entry_count), "result changed while stalled")

    `VPA_ASSERT_IMP(a_count_range, o_out_valid, o_entry_count != '0 && o_entry_count <= CW'(MAX_ENTRIES), "entry count out of range")

    `VPA_ASSERT_IMP(a_fail_zero, o_out_valid && o_status != vpa_pkg::ST_OK, o_granted_index == '0 && o_start_address == '0, "failed result carries a grant")

    `VPA_ASSERT_NXT(a_init_stall, psel && penable && pwrite && paddr == vpa_pkg::REG_MEM_SIZE, o_in_stall, "input taken during table rebuild")

endmodule

bind variable_partition_allocator_top vpa_checker #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .ADDR_BITS  (ADDR_BITS)
) u_vpa_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_status       (o_status),
    .o_granted_index(o_granted_index),
    .o_start_address(o_start_address),
    .o_entry_count  (o_entry_count)
);

@@ verif/variable_partition_allocator_top_tb.sv @@
// Testbench for variable_partition_allocator_top: directed and random allocate/free traffic.
// Depends on vpa_pkg and the allocator RTL; a local table model predicts every result.
`timescale 1ns / 1ps

module testbench;

    localparam int SLOTS       = 16;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE      = 60;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  granted;
        logic [15:0] addr;
        logic [4:0]  count;
    } t_alloc_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [vpa_pkg::PADDR_BITS-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_opcode;
    logic [15:0] i_request_size;
    logic [7:0]  i_owner_id;
    logic [3:0]  i_entry_index;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [1:0]  o_status;
    logic [3:0]  o_granted_index;
    logic [15:0] o_start_address;
    logic [4:0]  o_entry_count;

    variable_partition_allocator_top dut (.*);

    // table model
    logic [15:0] tbl_start [SLOTS];
    logic [15:0] tbl_size  [SLOTS];
    logic [7:0]  tbl_owner [SLOTS];
    int          n_used;
    int          cursor;
    logic [1:0]  fit_rule;
    logic [15:0] mem_total;

    t_alloc_result pending_results[$];
    int fail_count;
    int idle_cycles;
    bit calm;
    int out_hold;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic void table_clear();
        for (int k = 0; k < SLOTS; k++) begin
            tbl_start[k] = '0;
            tbl_size[k]  = '0;
            tbl_owner[k] = '0;
        end
        tbl_size[0] = mem_total;
        n_used = 1;
        cursor = 0;
    endfunction

    function automatic void drop_slot(int at);
        for (int k = at; k + 1 < n_used; k++) begin
            tbl_start[k] = tbl_start[k+1];
            tbl_size[k]  = tbl_size[k+1];
            tbl_owner[k] = tbl_owner[k+1];
        end
        n_used--;
        tbl_start[n_used] = '0;
        tbl_size[n_used]  = '0;
        tbl_owner[n_used] = '0;
    endfunction

    function automatic bit bool_fits(int k, logic [15:0] want);
        return tbl_owner[k] == 0 && tbl_size[k] >= want;
    endfunction

    // returns SLOTS when nothing fits
    function automatic int pick_slot(logic [15:0] want);
        int best;
        int pos;
        best = SLOTS;
        case (fit_rule)
            vpa_pkg::FIT_FIRST: begin
                for (int k = 0; k < n_used; k++)
                    if (bool_fits(k, want)) return k;
            end
            vpa_pkg::FIT_BEST: begin
                for (int k = 0; k < n_used; k++)
                    if (bool_fits(k, want) && (best == SLOTS || tbl_size[k] < tbl_size[best]))
                        best = k;
            end
            vpa_pkg::FIT_NEXT: begin
                pos = (cursor < n_used) ? cursor : 0;
                for (int n = 0; n < n_used; n++) begin
                    if (bool_fits(pos, want)) return pos;
                    pos = (pos + 1 < n_used) ? pos + 1 : 0;
                end
            end
            default: ;
        endcase
        return best;
    endfunction

    function automatic t_alloc_result apply_request(logic op, logic [15:0] want,
                                                    logic [7:0] owner, logic [3:0] idx);
        t_alloc_result r;
        int pos;
        r = '0;
        if (op == vpa_pkg::OP_ALLOC) begin
            pos = (want == 0 || owner == 0) ? SLOTS : pick_slot(want);
            if (pos >= SLOTS) begin
                r.status = vpa_pkg::ST_NO_FIT;
            end else if (tbl_size[pos] > want && n_used >= SLOTS) begin
                r.status = vpa_pkg::ST_FULL;
            end else begin
                if (tbl_size[pos] > want) begin
                    for (int k = n_used; k > pos + 1; k--) begin
                        tbl_start[k] = tbl_start[k-1];
                        tbl_size[k]  = tbl_size[k-1];
                        tbl_owner[k] = tbl_owner[k-1];
                    end
                    tbl_start[pos+1] = tbl_start[pos] + want;
                    tbl_size[pos+1]  = tbl_size[pos] - want;
                    tbl_owner[pos+1] = '0;
                    tbl_size[pos]    = want;
                    n_used++;
                end
                tbl_owner[pos] = owner;
                if (fit_rule == vpa_pkg::FIT_NEXT) cursor = pos;
                r.status  = vpa_pkg::ST_OK;
                r.granted = pos[3:0];
                r.addr    = tbl_start[pos];
            end
        end else begin
            if (idx >= n_used || tbl_owner[idx] == 0) begin
                r.status = vpa_pkg::ST_BAD_FREE;
            end else begin
                pos = idx;
                tbl_owner[pos] = '0;
                if (pos > 0 && tbl_owner[pos-1] == 0) begin
                    tbl_size[pos-1] = tbl_size[pos-1] + tbl_size[pos];
                    drop_slot(pos);
                    pos--;
                end
                if (pos + 1 < n_used && tbl_owner[pos+1] == 0) begin
                    tbl_size[pos] = tbl_size[pos] + tbl_size[pos+1];
                    drop_slot(pos + 1);
                end
            end
        end
        r.count = n_used[4:0];
        return r;
    endfunction

    // one request transfer; valid stays high on return
    task automatic send_request(logic op, logic [15:0] want, logic [7:0] owner,
                                logic [3:0] idx);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_opcode       <= op;
        i_request_size <= want;
        i_owner_id     <= owner;
        i_entry_index  <= idx;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_results.push_back(apply_request(op, want, owner, idx));
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic reg_write(logic [vpa_pkg::PADDR_BITS-1:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == vpa_pkg::REG_STRATEGY) begin
            fit_rule = data[1:0];
        end else begin
            mem_total = data[15:0];
            table_clear();
        end
    endtask

    task automatic configure(logic [1:0] rule, logic [15:0] total);
        drain();
        reg_write(vpa_pkg::REG_STRATEGY, {30'd0, rule});
        reg_write(vpa_pkg::REG_MEM_SIZE, {16'd0, total});
    endtask

    task automatic test_refusals();
        send_request(vpa_pkg::OP_ALLOC, 16'd0, 8'd1, 4'd0);
        send_request(vpa_pkg::OP_ALLOC, 16'd10, 8'd0, 4'd0);
        send_request(vpa_pkg::OP_ALLOC, 16'hFFFF, 8'hFF, 4'hF);
        send_request(vpa_pkg::OP_FREE, 16'd0, 8'd0, 4'hF);
        send_request(vpa_pkg::OP_FREE, 16'd0, 8'd0, 4'd0);
    endtask

    task automatic test_split_merge();
        send_request(vpa_pkg::OP_ALLOC, 16'd100, 8'd1, 4'd0);
        send_request(vpa_pkg::OP_ALLOC, 16'd200, 8'hFF, 4'd0);
        send_request(vpa_pkg::OP_ALLOC, 16'd50, 8'd3, 4'd0);
        send_request(vpa_pkg::OP_FREE, 16'd0, 8'd0, 4'd0);
        send_request(vpa_pkg::OP_FREE, 16'd0, 8'd0, 4'd0);
        send_request(vpa_pkg::OP_FREE, 16'd0, 8'd0, 4'd2);
        send_request(vpa_pkg::OP_FREE, 16'd0, 8'd0, 4'd1);
        send_request(vpa_pkg::OP_ALLOC, 16'd512, 8'd9, 4'd0);
    endtask

    task automatic test_table_full();
        configure(vpa_pkg::FIT_FIRST, 16'hFFFF);
        for (int k = 0; k < SLOTS - 1; k++)
            send_request(vpa_pkg::OP_ALLOC, 16'd1, 8'(k + 1), 4'd0);
        send_request(vpa_pkg::OP_ALLOC, 16'd1, 8'd77, 4'd0);
        send_request(vpa_pkg::OP_ALLOC, 16'hFFF0, 8'd78, 4'd0);
    endtask

    task automatic test_odd_settings();
        configure(vpa_pkg::FIT_NONE, 16'd512);
        send_request(vpa_pkg::OP_ALLOC, 16'd1, 8'd1, 4'd0);
        configure(vpa_pkg::FIT_BEST, 16'd0);
        send_request(vpa_pkg::OP_ALLOC, 16'd1, 8'd1, 4'd0);
        configure(vpa_pkg::FIT_NEXT, 16'd1);
        send_request(vpa_pkg::OP_ALLOC, 16'd1, 8'd1, 4'd0);
    endtask

    task automatic test_random_traffic(logic [1:0] rule, logic [15:0] total, int items);
        int owned[$];
        logic [15:0] want;
        logic [7:0]  owner;
        logic [3:0]  idx;
        configure(rule, total);
        for (int n = 0; n < items; n++) begin
            calm = (n < 40);
            if ($urandom_range(0, 99) < 40) begin
                owned.delete();
                for (int k = 0; k < n_used; k++)
                    if (tbl_owner[k] != 0) owned.push_back(k);
                if (owned.size() != 0 && $urandom_range(0, 9) < 8)
                    idx = 4'(owned[$urandom_range(0, owned.size() - 1)]);
                else
                    idx = 4'($urandom_range(0, 15));
                send_request(vpa_pkg::OP_FREE, 16'($urandom), 8'($urandom), idx);
            end else begin
                if ($urandom_range(0, 9) == 0)
                    want = 16'($urandom);
                else
                    want = 16'($urandom_range(1, total / 6 + 1));
                owner = ($urandom_range(0, 49) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
                send_request(vpa_pkg::OP_ALLOC, want, owner, 4'($urandom));
            end
        end
        calm = 1'b0;
    endtask

    // result checker and output stall
    always @(posedge i_clk) begin
        t_alloc_result exp_r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with none expected: status %0d index %0d addr %0d count %0d",
                         $time, o_status, o_granted_index, o_start_address, o_entry_count);
                fail_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (o_status !== exp_r.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, exp_r.status, o_status);
                    fail_count++;
                end
                if (o_granted_index !== exp_r.granted) begin
                    $display("%0t: granted_index expected %0d actual %0d",
                             $time, exp_r.granted, o_granted_index);
                    fail_count++;
                end
                if (o_start_address !== exp_r.addr) begin
                    $display("%0t: start_address expected %0d actual %0d",
                             $time, exp_r.addr, o_start_address);
                    fail_count++;
                end
                if (o_entry_count !== exp_r.count) begin
                    $display("%0t: entry_count expected %0d actual %0d",
                             $time, exp_r.count, o_entry_count);
                    fail_count++;
                end
            end
            out_hold = calm ? 0 : $urandom_range(0, 19);
        end
        i_out_stall <= (out_hold > 0);
        if (out_hold > 0) out_hold--;
    end

    // watchdog: cycles with no transfer on either channel and no register access
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || psel) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("variable_partition_allocator_top regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        fail_count     = 0;
        idle_cycles    = 0;
        out_hold       = 0;
        calm           = 1'b0;
        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        i_in_valid     = 1'b0;
        i_out_stall    = 1'b0;
        i_opcode       = 1'b0;
        i_request_size = '0;
        i_owner_id     = '0;
        i_entry_index  = '0;
        fit_rule       = vpa_pkg::FIT_FIRST;
        mem_total      = 16'(vpa_pkg::MSIZE_RESET);
        table_clear();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_refusals();
        test_split_merge();
        test_table_full();
        test_odd_settings();
        test_random_traffic(vpa_pkg::FIT_FIRST, 16'd1024, 240);
        test_random_traffic(vpa_pkg::FIT_BEST, 16'hFFFF, 240);
        test_random_traffic(vpa_pkg::FIT_NEXT, 16'd512, 240);
        test_random_traffic(vpa_pkg::FIT_BEST, 16'd64, 200);
        test_random_traffic(vpa_pkg::FIT_NEXT, 16'hFFFF, 240);
        test_random_traffic(vpa_pkg::FIT_FIRST, 16'($urandom_range(1, 65535)), 240);
        test_random_traffic(vpa_pkg::FIT_NONE, 16'd300, 30);
        drain();

        if (fail_count == 0)
            $display("variable_partition_allocator_top regression: pass");
        else
            $display("variable_partition_allocator_top regression: fail");
        $finish;
    end

endmodule
